### rtl/drc_pkg.sv
`timescale 1ns / 1ps
// drc_pkg: shared types and constants of the duplicate request cache.
// No dependencies.
package drc_pkg;

	localparam logic [31:0] RESET_MIN_XID = 32'd1000000;
	localparam logic [31:0] XID_ALL_ONES  = 32'hFFFF_FFFF;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_SAVE   = 1'b1;

	// stored request, first member in the highest bits
	typedef struct packed {
		logic [15:0] port;
		logic [31:0] ip;
		logic [31:0] xid;
		logic [7:0]  proc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

### rtl/drc_ram.sv
`timescale 1ns / 1ps
// drc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module drc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/duplicate_request_cache.sv
`timescale 1ns / 1ps
// duplicate_request_cache: ring of recent once-only requests with duplicate lookup.
// Depends on drc_pkg and drc_ram.
//
//  channel  dir  signals                     payload (lowest bit up)
//  s_       in   s_tvalid s_tready s_tdata   proc_number, transaction_id, client_ip,
//                s_tuser                     client_port; tuser: operation
//  m_       out  m_tvalid m_tready m_tdata   is_duplicate, id_valid, zero pad
//  cfg_     in   cfg_we cfg_wdata            min_valid_xid
//
// A save or an invalid id goes straight to ST_FINISH; a valid lookup first scans the entry
// RAM in ST_SCAN, one read per cycle through its single read port.
// One transaction is processed at a time; the result register frees the engine unless
// the previous result is still waiting, in which case it holds in ST_FINISH.
// Reset clears per-entry valid bits at once; an entry never written reads as all zero.
module duplicate_request_cache #(
	parameter int CACHE_ENTRIES = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // proc_number, transaction_id, client_ip, client_port
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // is_duplicate, id_valid, 6 zero bits
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import drc_pkg::*;

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
	localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

	state_t state_q, state_d;

	logic [31:0]              min_xid_q;
	logic [IDX_W-1:0]         wptr_q;
	logic [CACHE_ENTRIES-1:0] ent_vld_q;
	entry_t                   rec_q;
	logic                     op_q;
	logic                     xid_ok_q;
	logic                     dup_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic                     m_tvalid_q;
	logic [7:0]               m_tdata_q;

	entry_t             in_rec;
	logic               xid_ok;
	logic               accept;
	logic               do_save;
	logic               start_scan;
	logic               issue;
	logic               out_free;
	logic               load_out;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t             rd_entry;
	logic               match;

	assign in_rec = entry_t'(s_tdata);
	assign xid_ok = (in_rec.xid != XID_ALL_ONES) && (in_rec.xid >= min_xid_q);

	drc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_ENTRIES),
		.ADDR_W(IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (do_save),
		.waddr(wptr_q),
		.wdata(ENTRY_W'(in_rec)),
		.re   (issue),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_entry = ent_vld_q[rd_idx_s1] ? entry_t'(ram_rdata) : '0;
	assign match    = rd_vld_s1 && (rd_entry == rec_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		accept     = 1'b0;
		do_save    = 1'b0;
		start_scan = 1'b0;
		issue      = 1'b0;
		out_free   = !m_tvalid_q || m_tready;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready   = 1'b1;
				accept     = s_tvalid;
				do_save    = accept && (s_tuser == OP_SAVE) && xid_ok;
				start_scan = accept && (s_tuser == OP_LOOKUP) && xid_ok;
				if (start_scan) begin
					state_d = ST_SCAN;
				end else if (accept) begin
					state_d = ST_FINISH;
				end
			end
			ST_SCAN: begin
				issue = cnt_q < CNT_END;
				if (rd_vld_s1 && (rd_idx_s1 == LAST_IDX)) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_xid_q  <= RESET_MIN_XID;
			wptr_q     <= '0;
			ent_vld_q  <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				min_xid_q <= cfg_wdata;
			end
			if (do_save) begin
				ent_vld_q[wptr_q] <= 1'b1;
				wptr_q <= (wptr_q == LAST_IDX) ? '0 : wptr_q + 1'b1;
			end
			if (start_scan) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			rd_vld_s1 <= issue;
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q    <= in_rec;
			op_q     <= s_tuser;
			xid_ok_q <= xid_ok;
			dup_q    <= 1'b0;
		end else if (match) begin
			dup_q <= 1'b1;
		end
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (load_out) begin
			m_tdata_q <= {6'b0, xid_ok_q, dup_q && (op_q == OP_LOOKUP)};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_wptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wptr_q <= LAST_IDX)
		else $error("write pointer out of range");

	a_dup_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[0] && !m_tdata_q[1]))
		else $error("duplicate reported for invalid id");

	a_save_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && (op_q == OP_SAVE) |=> !m_tdata_q[0])
		else $error("save result reports duplicate");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN))
		else $error("read data returned outside scan");
`endif

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for duplicate_request_cache over its stream ports.
// Depends on drc_pkg and the duplicate_request_cache RTL; predicts verdicts itself but for typed table rows.
module testbench;
	import drc_pkg::*;

	localparam int CACHE_ENTRIES = 10;
	localparam int LIMIT         = 400000;
	localparam int PHASE_ITEMS   = 213;

	typedef struct packed {
		logic valid;
		logic dup;
	} verdict_t;

	typedef struct {
		logic        is_cfg;
		logic [31:0] cfg_val;
		logic        op;
		entry_t      rq;
		logic        typed;
		verdict_t    want;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;

	// verdict pinned to the transaction on the bus, for table rows read off by hand
	logic     pin_typed   = 1'b0;
	verdict_t pin_verdict = '0;

	// mirror of the cache
	entry_t      ring [CACHE_ENTRIES];
	int          ring_wp = 0;
	logic [31:0] min_xid = RESET_MIN_XID;

	verdict_t verdict_q [$];
	verdict_t want_v;
	verdict_t got_v;
	entry_t   saved_hist [$];
	row_t     plan [$];

	int   faults       = 0;
	int   taken        = 0;
	int   cycles       = 0;
	int   src_idle_pct = 35;
	int   sink_idle_pct = 35;
	logic hold_off     = 1'b0;

	duplicate_request_cache #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic verdict_t judge_request(logic op, entry_t rq);
		verdict_t v;
		v.valid = (rq.xid != XID_ALL_ONES) && (rq.xid >= min_xid);
		v.dup   = 1'b0;
		if (v.valid) begin
			if (op == OP_SAVE) begin
				ring[ring_wp] = rq;
				ring_wp = (ring_wp == CACHE_ENTRIES - 1) ? 0 : ring_wp + 1;
			end else begin
				foreach (ring[i])
					if (ring[i] == rq)
						v.dup = 1'b1;
			end
		end
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				min_xid = cfg_wdata;
			if (m_tvalid && m_tready) begin
				got_v = verdict_t'(m_tdata[1:0]);
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual dup %b valid %b",
						$time, got_v.dup, got_v.valid);
					faults++;
				end else begin
					want_v = verdict_q.pop_front();
					if (got_v.dup !== want_v.dup) begin
						$display("%0t: is_duplicate expected %b actual %b",
							$time, want_v.dup, got_v.dup);
						faults++;
					end
					if (got_v.valid !== want_v.valid) begin
						$display("%0t: id_valid expected %b actual %b",
							$time, want_v.valid, got_v.valid);
						faults++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want_v = judge_request(s_tuser, entry_t'(s_tdata));
				verdict_q.push_back(pin_typed ? pin_verdict : want_v);
				taken++;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_off)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		wait (taken >= 300);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	function automatic row_t mk(logic op, logic [7:0] proc, logic [31:0] xid,
		logic [31:0] ip, logic [15:0] port, logic typed, logic dup, logic valid);
		row_t r;
		r.is_cfg     = 1'b0;
		r.cfg_val    = '0;
		r.op         = op;
		r.rq.proc    = proc;
		r.rq.xid     = xid;
		r.rq.ip      = ip;
		r.rq.port    = port;
		r.typed      = typed;
		r.want.dup   = dup;
		r.want.valid = valid;
		return r;
	endfunction

	function automatic row_t mk_min(logic [31:0] v);
		row_t r;
		r         = mk(OP_LOOKUP, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0);
		r.is_cfg  = 1'b1;
		r.cfg_val = v;
		return r;
	endfunction

	function automatic logic [31:0] pick_xid();
		logic [63:0] span;
		logic [31:0] x;
		span = 64'hFFFF_FFFF - {32'd0, min_xid};
		case ($urandom_range(11))
			0: x = XID_ALL_ONES;
			1: x = min_xid;
			2: x = min_xid - 1;
			3: x = $urandom;
			4: x = min_xid + 1;
			default: begin
				if (span == 0)
					x = min_xid;
				else
					x = min_xid + 32'({$urandom, $urandom} % span);
			end
		endcase
		return x;
	endfunction

	task automatic draw_request(output logic op, output entry_t rq);
		int          k;
		logic [87:0] bits;
		k  = $urandom_range(99);
		op = OP_LOOKUP;
		rq = ring[$urandom_range(CACHE_ENTRIES - 1)];
		if (k < 32) begin
			op      = OP_SAVE;
			rq.proc = 8'($urandom);
			rq.xid  = pick_xid();
			rq.ip   = $urandom;
			rq.port = 16'($urandom);
			saved_hist.push_back(rq);
			if (saved_hist.size() > 40)
				void'(saved_hist.pop_front());
		end else if (k < 57) begin
		end else if (k < 69) begin
			if (saved_hist.size() != 0)
				rq = saved_hist[$urandom_range(saved_hist.size() - 1)];
		end else if (k < 81) begin
			bits = rq;
			bits[$urandom_range(87)] ^= 1'b1;
			rq = entry_t'(bits);
		end else if (k < 87) begin
			op = OP_SAVE;
		end else if (k < 90) begin
			op = 1'($urandom_range(1));
			rq = '0;
		end else begin
			op      = 1'($urandom_range(1));
			rq.proc = 8'($urandom);
			rq.xid  = $urandom_range(1) ? $urandom : pick_xid();
			rq.ip   = $urandom;
			rq.port = 16'($urandom);
		end
	endtask

	task automatic offer(logic op, entry_t rq, logic typed, verdict_t tv);
		@(negedge clk);
		while (!hold_off && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid    <= 1'b1;
		s_tuser     <= op;
		s_tdata     <= rq;
		pin_typed   <= typed;
		pin_verdict <= tv;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic set_min(logic [31:0] v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (CACHE_ENTRIES + 8) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic        op;
		entry_t      rq;
		logic [31:0] phase_min [4];

		foreach (ring[i])
			ring[i] = '0;

		plan.push_back(mk(OP_LOOKUP, 8'h00, RESET_MIN_XID, 0, 16'h0000, 1, 0, 1));
		plan.push_back(mk(OP_LOOKUP, 8'h00, RESET_MIN_XID - 1, 0, 16'h0000, 1, 0, 0));
		plan.push_back(mk(OP_LOOKUP, 8'hFF, XID_ALL_ONES, '1, 16'hFFFF, 1, 0, 0));
		plan.push_back(mk(OP_SAVE, 8'hFF, XID_ALL_ONES, '1, 16'hFFFF, 1, 0, 0));
		plan.push_back(mk(OP_SAVE, 8'hFF, 32'hFFFF_FFFE, '1, 16'hFFFF, 1, 0, 1));
		plan.push_back(mk(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFE, '1, 16'hFFFF, 1, 1, 1));
		plan.push_back(mk(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFE, '1, 16'hFFFE, 0, 0, 0));
		plan.push_back(mk(OP_LOOKUP, 8'h7F, 32'hFFFF_FFFE, '1, 16'hFFFF, 0, 0, 0));
		plan.push_back(mk(OP_SAVE, 8'h00, RESET_MIN_XID, 0, 16'h0000, 1, 0, 1));
		plan.push_back(mk(OP_LOOKUP, 8'h00, RESET_MIN_XID, 0, 16'h0000, 1, 1, 1));
		plan.push_back(mk(OP_SAVE, 8'h00, RESET_MIN_XID - 1, 0, 16'h0000, 1, 0, 0));
		plan.push_back(mk(OP_LOOKUP, 8'h00, RESET_MIN_XID, 32'd1, 16'h0000, 0, 0, 0));
		// minimum zero: cleared entries match an all-zero request
		plan.push_back(mk_min(32'd0));
		plan.push_back(mk(OP_LOOKUP, 8'h00, 32'd0, 0, 16'h0000, 0, 0, 0));
		plan.push_back(mk(OP_SAVE, 8'h00, 32'd0, 32'd5, 16'h0006, 1, 0, 1));
		plan.push_back(mk(OP_LOOKUP, 8'h00, 32'd0, 32'd5, 16'h0006, 1, 1, 1));
		plan.push_back(mk(OP_LOOKUP, 8'h00, XID_ALL_ONES, 0, 16'h0000, 1, 0, 0));
		plan.push_back(mk_min(XID_ALL_ONES));
		plan.push_back(mk(OP_SAVE, 8'h01, 32'hFFFF_FFFE, 32'd1, 16'h0001, 1, 0, 0));
		plan.push_back(mk(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFE, '1, 16'hFFFF, 1, 0, 0));
		plan.push_back(mk_min(32'hFFFF_FFFE));
		plan.push_back(mk(OP_LOOKUP, 8'hFF, 32'hFFFF_FFFE, '1, 16'hFFFF, 1, 1, 1));
		plan.push_back(mk(OP_SAVE, 8'h55, 32'hFFFF_FFFE, 32'hA5A5_A5A5, 16'h5A5A, 1, 0, 1));
		plan.push_back(mk(OP_LOOKUP, 8'h55, 32'hFFFF_FFFE, 32'hA5A5_A5A5, 16'h5A5A,
			1, 1, 1));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				set_min(plan[i].cfg_val);
			else
				offer(plan[i].op, plan[i].rq, plan[i].typed, plan[i].want);
		end

		phase_min[0] = RESET_MIN_XID;
		phase_min[1] = 32'd0;
		phase_min[2] = $urandom;
		phase_min[3] = 32'd1;
		foreach (phase_min[p]) begin
			set_min(phase_min[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 1) begin
					src_idle_pct  = (n < 120) ? 0 : 35;
					sink_idle_pct = (n < 120) ? 0 : 35;
				end
				draw_request(op, rq);
				offer(op, rq, 1'b0, '0);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(negedge clk);
		repeat (CACHE_ENTRIES + 30) @(negedge clk);
		if (faults == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
